// ===== sv/mlv_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// mlv_pkg
// Shared types and constants of the majority label vote block.
// ----------------------------------------------------------------------------
package mlv_pkg;

	localparam int LABEL_SLOTS  = 64;
	localparam int COUNT_BITS   = 16;
	localparam int MAX_VERTICES = 16777216;

	localparam int LBL_BITS = (LABEL_SLOTS > 1) ? $clog2(LABEL_SLOTS) : 1;
	localparam int NL_W     = 7;   // num_labels register
	localparam int TOL_W    = 17;  // tolerance_q16 register
	localparam int NV_W     = 25;  // vertex count register
	localparam int CHG_W    = 25;  // change counter
	localparam int LAB_W    = 16;  // input label fields
	localparam int KIND_W   = 2;
	localparam int CFG_W    = 25;  // widest register
	localparam int IDX_W    = 2;   // register index
	localparam int FRAC_W   = 16;  // Q25.16 scaling of the change count
	localparam int PROD_W   = TOL_W + NV_W;

	// queue depth between stages, power of two
	localparam int Q_DEPTH = 2;
	localparam int QP_W    = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
	localparam int QC_W    = $clog2(Q_DEPTH + 1);

	localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;
	localparam logic [CHG_W-1:0]      CHG_MAX = '1;

	localparam logic [KIND_W-1:0] KIND_VOTE  = 2'd0;
	localparam logic [KIND_W-1:0] KIND_CLOSE = 2'd1;
	localparam logic [KIND_W-1:0] KIND_SWEEP = 2'd2;

	localparam logic [IDX_W-1:0] REG_NUM_LABELS    = 2'd0;
	localparam logic [IDX_W-1:0] REG_TOLERANCE     = 2'd1;
	localparam logic [IDX_W-1:0] REG_VERTEX_COUNT  = 2'd2;

	localparam logic RPT_GROUP = 1'b0;
	localparam logic RPT_SWEEP = 1'b1;

	typedef enum logic [1:0] {
		OP_VOTE,
		OP_CLOSE,
		OP_SWEEP
	} op_t;

	typedef struct packed {
		op_t                       op;
		logic [LBL_BITS-1:0]       lbl;
		logic signed [LAB_W-1:0]   old_label;
		logic                      count_changes;
	} cmd_t;

	typedef struct packed {
		logic [NL_W-1:0]  n_eff;
		logic [TOL_W-1:0] tol;
		logic [NV_W-1:0]  nv;
	} cfg_t;

	typedef struct packed {
		logic                report_kind;
		logic [LBL_BITS-1:0] winner_label;
		logic                changed;
		logic                converged;
		logic [CHG_W-1:0]    change_total;
	} res_t;

endpackage
`default_nettype wire

// ===== sv/majority_label_vote.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// majority_label_vote
// One label-propagation majority vote with change counting and a
// convergence report at sweep end.
// ----------------------------------------------------------------------------
// Usage:
//  Input side is a queue: a word is taken on push && !full. Vote words add to
//  the count of their label, close words yield the winning label, sweep-end
//  words yield a convergence report. Votes and unused kinds yield nothing.
//  Result side is a queue: the oldest result sits on the ports while empty is
//  low and is taken on pop && !empty. Registers are written through
//  cfg_we/cfg_index/cfg_data; the user must do so only while idle, unenforced.
// Timing:
//  The back end executes one command at a time. A vote reads the count
//  memory, then writes it back. A close scans the N clamped labels for the
//  argmax, reading one count per cycle from the single memory read port,
//  then passes ST_SCAN_LAST and ST_FIN. A sweep end forms the product, then
//  compares. A result enters the result queue as its command leaves ST_FIN
//  and shows on the ports once older results are popped. Two-entry queues
//  at both sides let the front accept while the back works, and let the
//  back finish one more result while pop is low.
// Reset: queues empty, counts and change counter zero, registers at defaults.
//  When the receiver stalls, the result queue fills and the back end holds
//  in its final state; the command queue then fills and full rises.
// ----------------------------------------------------------------------------
module majority_label_vote (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                push,
	output logic                                     full,
	input  wire logic        [mlv_pkg::KIND_W-1:0]   kind,
	input  wire logic signed [mlv_pkg::LAB_W-1:0]    label,
	input  wire logic signed [mlv_pkg::LAB_W-1:0]    old_label,
	input  wire logic                                count_changes,
	output logic                                     empty,
	input  wire logic                                pop,
	output logic                                     report_kind,
	output logic             [mlv_pkg::LBL_BITS-1:0] winner_label,
	output logic                                     changed,
	output logic                                     converged,
	output logic             [mlv_pkg::CHG_W-1:0]    change_total,
	input  wire logic                                cfg_we,
	input  wire logic        [mlv_pkg::IDX_W-1:0]    cfg_index,
	input  wire logic        [mlv_pkg::CFG_W-1:0]    cfg_data
);

	logic [mlv_pkg::NL_W-1:0]  num_labels_q;
	logic [mlv_pkg::TOL_W-1:0] tol_q;
	logic [mlv_pkg::NV_W-1:0]  nv_q;
	mlv_pkg::cfg_t             cfg;
	logic                      cmd_valid;
	mlv_pkg::cmd_t             cmd;
	logic                      cmd_take;
	mlv_pkg::res_t             res;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_labels_q <= mlv_pkg::NL_W'(64);
			tol_q        <= mlv_pkg::TOL_W'(655);
			nv_q         <= mlv_pkg::NV_W'(1);
		end else if (cfg_we) begin
			case (cfg_index)
				mlv_pkg::REG_NUM_LABELS:   num_labels_q <= cfg_data[mlv_pkg::NL_W-1:0];
				mlv_pkg::REG_TOLERANCE:    tol_q        <= cfg_data[mlv_pkg::TOL_W-1:0];
				mlv_pkg::REG_VERTEX_COUNT: nv_q         <= cfg_data[mlv_pkg::NV_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// clamp label count to 1..LABEL_SLOTS
	always_comb begin
		cfg.tol = tol_q;
		cfg.nv  = nv_q;
		if (num_labels_q == '0) begin
			cfg.n_eff = mlv_pkg::NL_W'(1);
		end else if (num_labels_q > mlv_pkg::NL_W'(mlv_pkg::LABEL_SLOTS)) begin
			cfg.n_eff = mlv_pkg::NL_W'(mlv_pkg::LABEL_SLOTS);
		end else begin
			cfg.n_eff = num_labels_q;
		end
	end

	mlv_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.push          (push),
		.full          (full),
		.kind          (kind),
		.label         (label),
		.old_label     (old_label),
		.count_changes (count_changes),
		.n_eff         (cfg.n_eff),
		.cmd_valid     (cmd_valid),
		.cmd           (cmd),
		.cmd_take      (cmd_take)
	);

	mlv_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.cmd_valid (cmd_valid),
		.cmd       (cmd),
		.cmd_take  (cmd_take),
		.empty     (empty),
		.pop       (pop),
		.res       (res)
	);

	assign report_kind  = res.report_kind;
	assign winner_label = res.winner_label;
	assign changed      = res.changed;
	assign converged    = res.converged;
	assign change_total = res.change_total;

endmodule
`default_nettype wire

// ===== sv/mlv_hist.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// mlv_hist
// Per-label vote count memory, registered read, one valid bit per entry so
// that a close clears every count by clearing the valid bits.
// ----------------------------------------------------------------------------
module mlv_hist (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            rd_en,
	input  wire logic [mlv_pkg::LBL_BITS-1:0]    rd_addr,
	output logic      [mlv_pkg::COUNT_BITS-1:0]  rd_data,
	input  wire logic                            wr_en,
	input  wire logic [mlv_pkg::LBL_BITS-1:0]    wr_addr,
	input  wire logic [mlv_pkg::COUNT_BITS-1:0]  wr_data,
	input  wire logic                            clr
);

	logic [mlv_pkg::COUNT_BITS-1:0]  mem [mlv_pkg::LABEL_SLOTS];
	logic [mlv_pkg::COUNT_BITS-1:0]  rd_q;
	logic [mlv_pkg::LABEL_SLOTS-1:0] vld_q;
	logic                            rd_vld_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_q <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q    <= '0;
			rd_vld_q <= 1'b0;
		end else begin
			if (clr) begin
				vld_q <= '0;
			end else if (wr_en) begin
				vld_q[wr_addr] <= 1'b1;
			end
			if (rd_en) begin
				rd_vld_q <= vld_q[rd_addr];
			end
		end
	end

	// an entry not written since the last clear counts zero
	assign rd_data = rd_vld_q ? rd_q : '0;

endmodule
`default_nettype wire

// ===== sv/mlv_front.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// mlv_front
// Accepts input words, drops unused kinds and out-of-range votes, and queues
// the rest as commands for the back end.
// ----------------------------------------------------------------------------
module mlv_front (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                push,
	output logic                                     full,
	input  wire logic        [mlv_pkg::KIND_W-1:0]   kind,
	input  wire logic signed [mlv_pkg::LAB_W-1:0]    label,
	input  wire logic signed [mlv_pkg::LAB_W-1:0]    old_label,
	input  wire logic                                count_changes,
	input  wire logic        [mlv_pkg::NL_W-1:0]     n_eff,
	output logic                                     cmd_valid,
	output mlv_pkg::cmd_t                            cmd,
	input  wire logic                                cmd_take
);

	mlv_pkg::cmd_t             q_mem [mlv_pkg::Q_DEPTH];
	logic [mlv_pkg::QP_W-1:0]  wr_ptr_q;
	logic [mlv_pkg::QP_W-1:0]  rd_ptr_q;
	logic [mlv_pkg::QC_W-1:0]  cnt_q;
	logic                      in_range;
	logic                      keep;
	logic                      enq;
	logic                      deq;
	mlv_pkg::cmd_t             cmd_in;

	assign in_range = !label[mlv_pkg::LAB_W-1] &&
		(label < mlv_pkg::LAB_W'(n_eff));

	always_comb begin
		cmd_in               = '0;
		cmd_in.lbl           = label[mlv_pkg::LBL_BITS-1:0];
		cmd_in.old_label     = old_label;
		cmd_in.count_changes = count_changes;
		keep                 = 1'b0;
		case (kind)
			mlv_pkg::KIND_VOTE: begin
				cmd_in.op = mlv_pkg::OP_VOTE;
				keep      = in_range;
			end
			mlv_pkg::KIND_CLOSE: begin
				cmd_in.op = mlv_pkg::OP_CLOSE;
				keep      = 1'b1;
			end
			mlv_pkg::KIND_SWEEP: begin
				cmd_in.op = mlv_pkg::OP_SWEEP;
				keep      = 1'b1;
			end
			default: begin
				cmd_in.op = mlv_pkg::OP_VOTE;
				keep      = 1'b0;
			end
		endcase
	end

	assign full      = (cnt_q == mlv_pkg::QC_W'(mlv_pkg::Q_DEPTH));
	assign enq       = push && !full && keep;
	assign deq       = cmd_take && cmd_valid;
	assign cmd_valid = (cnt_q != '0);
	assign cmd       = q_mem[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (enq) begin
			q_mem[wr_ptr_q] <= cmd_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (enq) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (deq) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (enq && !deq) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (deq && !enq) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule
`default_nettype wire

// ===== sv/mlv_back.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// mlv_back
// Carries out queued commands: count updates, argmax scan on close, change
// counting and the convergence test, with a small result queue at the output.
// ----------------------------------------------------------------------------
module mlv_back (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire mlv_pkg::cfg_t cfg,
	input  wire logic          cmd_valid,
	input  wire mlv_pkg::cmd_t cmd,
	output logic               cmd_take,
	output logic               empty,
	input  wire logic          pop,
	output mlv_pkg::res_t      res
);

	typedef enum logic [4:0] {
		ST_IDLE      = 5'b00001,
		ST_VOTE_WR   = 5'b00010,
		ST_SCAN      = 5'b00100,
		ST_SCAN_LAST = 5'b01000,
		ST_FIN       = 5'b10000
	} state_t;

	state_t                             state_q;
	mlv_pkg::op_t                       op_q;
	logic [mlv_pkg::LBL_BITS-1:0]       lbl_q;
	logic signed [mlv_pkg::LAB_W-1:0]   old_q;
	logic                               cc_q;
	logic [mlv_pkg::LBL_BITS-1:0]       idx_q;
	logic [mlv_pkg::LBL_BITS-1:0]       pend_idx_q;
	logic                               pend_q;
	logic [mlv_pkg::LBL_BITS-1:0]       best_q;
	logic [mlv_pkg::COUNT_BITS-1:0]     best_cnt_q;
	logic [mlv_pkg::CHG_W-1:0]          chg_cnt_q;
	logic [mlv_pkg::PROD_W-1:0]         prod_q;

	logic                               rd_en;
	logic [mlv_pkg::LBL_BITS-1:0]       rd_addr;
	logic [mlv_pkg::COUNT_BITS-1:0]     rd_data;
	logic                               wr_en;
	logic [mlv_pkg::COUNT_BITS-1:0]     wr_data;
	logic                               clr;
	logic [mlv_pkg::LBL_BITS-1:0]       last_idx;
	logic                               chg;
	logic [mlv_pkg::CHG_W-1:0]          chg_next;
	logic                               conv;

	mlv_pkg::res_t                      q_mem [mlv_pkg::Q_DEPTH];
	logic [mlv_pkg::QP_W-1:0]           wr_ptr_q;
	logic [mlv_pkg::QP_W-1:0]           rd_ptr_q;
	logic [mlv_pkg::QC_W-1:0]           cnt_q;
	logic                               res_full;
	logic                               res_push;
	mlv_pkg::res_t                      res_in;
	logic                               deq;

	mlv_hist u_hist (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data),
		.wr_en   (wr_en),
		.wr_addr (lbl_q),
		.wr_data (wr_data),
		.clr     (clr)
	);

	assign last_idx = mlv_pkg::LBL_BITS'(cfg.n_eff - 1'b1);
	assign chg      = (old_q != mlv_pkg::LAB_W'(best_q));
	assign chg_next = (chg && cc_q && (chg_cnt_q != mlv_pkg::CHG_MAX)) ?
		chg_cnt_q + 1'b1 : chg_cnt_q;
	assign conv     = (mlv_pkg::PROD_W'({chg_cnt_q, mlv_pkg::FRAC_W'(0)}) < prod_q);
	assign wr_data  = (rd_data == mlv_pkg::CNT_MAX) ? rd_data : rd_data + 1'b1;
	assign res_full = (cnt_q == mlv_pkg::QC_W'(mlv_pkg::Q_DEPTH));

	always_comb begin
		cmd_take = 1'b0;
		rd_en    = 1'b0;
		rd_addr  = idx_q;
		wr_en    = 1'b0;
		clr      = 1'b0;
		res_push = 1'b0;
		res_in   = '0;
		case (state_q)
			ST_IDLE: begin
				cmd_take = cmd_valid;
				if (cmd_valid && cmd.op == mlv_pkg::OP_VOTE) begin
					rd_en   = 1'b1;
					rd_addr = cmd.lbl;
				end
			end
			ST_VOTE_WR: begin
				wr_en = 1'b1;
			end
			ST_SCAN: begin
				rd_en = 1'b1;
			end
			ST_SCAN_LAST: begin
			end
			ST_FIN: begin
				if (!res_full) begin
					res_push = 1'b1;
					if (op_q == mlv_pkg::OP_SWEEP) begin
						res_in.report_kind  = mlv_pkg::RPT_SWEEP;
						res_in.converged    = conv;
						res_in.change_total = chg_cnt_q;
					end else begin
						clr                 = 1'b1;
						res_in.report_kind  = mlv_pkg::RPT_GROUP;
						res_in.winner_label = best_q;
						res_in.changed      = chg;
						res_in.change_total = chg_next;
					end
				end
			end
			default: begin
			end
		endcase
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && cmd_valid) begin
			op_q  <= cmd.op;
			lbl_q <= cmd.lbl;
			old_q <= cmd.old_label;
			cc_q  <= cmd.count_changes;
			prod_q <= mlv_pkg::PROD_W'(cfg.tol) * mlv_pkg::PROD_W'(cfg.nv);
		end
		if (state_q == ST_SCAN) begin
			pend_idx_q <= idx_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			idx_q      <= '0;
			pend_q     <= 1'b0;
			best_q     <= '0;
			best_cnt_q <= '0;
			chg_cnt_q  <= '0;
		end else begin
			// compare runs in the cycle after its read is issued
			if (pend_q && rd_data > best_cnt_q) begin
				best_cnt_q <= rd_data;
				best_q     <= pend_idx_q;
			end
			case (state_q)
				ST_IDLE: begin
					if (cmd_valid) begin
						case (cmd.op)
							mlv_pkg::OP_VOTE: begin
								state_q <= ST_VOTE_WR;
							end
							mlv_pkg::OP_CLOSE: begin
								idx_q      <= '0;
								pend_q     <= 1'b0;
								best_q     <= '0;
								best_cnt_q <= '0;
								state_q    <= ST_SCAN;
							end
							default: begin
								state_q <= ST_FIN;
							end
						endcase
					end
				end
				ST_VOTE_WR: begin
					state_q <= ST_IDLE;
				end
				ST_SCAN: begin
					pend_q <= 1'b1;
					if (idx_q == last_idx) begin
						state_q <= ST_SCAN_LAST;
					end else begin
						idx_q <= idx_q + 1'b1;
					end
				end
				ST_SCAN_LAST: begin
					pend_q  <= 1'b0;
					state_q <= ST_FIN;
				end
				ST_FIN: begin
					if (!res_full) begin
						if (op_q == mlv_pkg::OP_SWEEP) begin
							chg_cnt_q <= '0;
						end else begin
							chg_cnt_q <= chg_next;
						end
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// result queue
	assign empty = (cnt_q == '0);
	assign deq   = pop && !empty;
	assign res   = q_mem[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (res_push) begin
			q_mem[wr_ptr_q] <= res_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (res_push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (deq) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (res_push && !deq) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (deq && !res_push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule
`default_nettype wire

// ===== sv/mlv_checker.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// mlv_checker
// Port-level checks of the majority label vote block, bound to the top.
// ----------------------------------------------------------------------------
module mlv_checker (
	input wire logic                            clk,
	input wire logic                            arst_n,
	input wire logic                            full,
	input wire logic                            empty,
	input wire logic                            pop,
	input wire logic                            report_kind,
	input wire logic [mlv_pkg::LBL_BITS-1:0]    winner_label,
	input wire logic                            changed,
	input wire logic                            converged,
	input wire logic [mlv_pkg::CHG_W-1:0]       change_total
);

	// the asynchronous reset leaves both queues reading clear
	a_reset_idle: assert property (@(posedge clk) !arst_n |=> empty && !full)
		else $error("queues not empty during reset");

	a_sweep_fields: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && report_kind == mlv_pkg::RPT_SWEEP) |-> (winner_label == '0 && !changed))
		else $error("sweep report carries group fields");

	a_group_fields: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && report_kind == mlv_pkg::RPT_GROUP) |-> !converged)
		else $error("group result flags convergence");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> (!empty && $stable(report_kind) && $stable(winner_label)
			&& $stable(changed) && $stable(converged) && $stable(change_total)))
		else $error("waiting result word changed");

endmodule

bind majority_label_vote mlv_checker u_mlv_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.full         (full),
	.empty        (empty),
	.pop          (pop),
	.report_kind  (report_kind),
	.winner_label (winner_label),
	.changed      (changed),
	.converged    (converged),
	.change_total (change_total)
);
`default_nettype wire

// ===== verif/majority_label_vote_tb.sv =====
// ----------------------------------------------------------------------------
// majority_label_vote_tb
// Self-checking bench: drives vote, close, sweep-end and unused words through
// the input queue, predicts every group winner and sweep report, and compares
// each popped word field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module majority_label_vote_tb;

	localparam logic [mlv_pkg::KIND_W-1:0] KIND_NONE = 2'd3;  // unused kind, dropped
	localparam int SETTLE   = 20;
	localparam int MAX_ERRS = 100;

	logic                                clk;
	logic                                arst_n;
	logic                                push;
	logic                                full;
	logic [mlv_pkg::KIND_W-1:0]          kind;
	logic signed [mlv_pkg::LAB_W-1:0]    label;
	logic signed [mlv_pkg::LAB_W-1:0]    old_label;
	logic                                count_changes;
	logic                                empty;
	logic                                pop;
	logic                                report_kind;
	logic [mlv_pkg::LBL_BITS-1:0]        winner_label;
	logic                                changed;
	logic                                converged;
	logic [mlv_pkg::CHG_W-1:0]           change_total;
	logic                                cfg_we;
	logic [mlv_pkg::IDX_W-1:0]           cfg_index;
	logic [mlv_pkg::CFG_W-1:0]           cfg_data;

	// predicted vote state and register copies
	logic [mlv_pkg::COUNT_BITS-1:0] vote_hist [mlv_pkg::LABEL_SLOTS];
	logic [mlv_pkg::CHG_W-1:0]      change_ctr;
	logic [mlv_pkg::NL_W-1:0]       reg_nlabels;
	logic [mlv_pkg::TOL_W-1:0]      reg_tol;
	logic [mlv_pkg::NV_W-1:0]       reg_nverts;
	mlv_pkg::res_t                  pending_reports[$];

	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	int pop_holdoff   = 0;
	int err_count     = 0;

	majority_label_vote uut (
		.clk, .arst_n, .push, .full, .kind, .label, .old_label, .count_changes,
		.empty, .pop, .report_kind, .winner_label, .changed, .converged,
		.change_total, .cfg_we, .cfg_index, .cfg_data
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin
		#3_000_000;
		$display("DONE: errors detected");
		$finish;
	end

	task automatic report_error(input string msg);
		if (err_count < MAX_ERRS)
			$display("ERROR @%0t: %s", $time, msg);
		err_count++;
	endtask

	function automatic int live_labels();
		int n;
		n = int'(reg_nlabels);
		if (n < 1) n = 1;
		if (n > mlv_pkg::LABEL_SLOTS) n = mlv_pkg::LABEL_SLOTS;
		return n;
	endfunction

	// argmax over valid labels, strict compare keeps the lowest label on a tie
	function automatic int leading_label();
		int n;
		int best;
		logic [mlv_pkg::COUNT_BITS-1:0] top;
		n = live_labels();
		best = 0;
		top = '0;
		for (int i = 0; i < n; i++) begin
			if (vote_hist[i] > top) begin
				top = vote_hist[i];
				best = i;
			end
		end
		return best;
	endfunction

	function automatic void clear_hist();
		for (int i = 0; i < mlv_pkg::LABEL_SLOTS; i++)
			vote_hist[i] = '0;
	endfunction

	function automatic void reset_model();
		clear_hist();
		change_ctr  = '0;
		reg_nlabels = mlv_pkg::NL_W'(64);
		reg_tol     = mlv_pkg::TOL_W'(655);
		reg_nverts  = mlv_pkg::NV_W'(1);
	endfunction

	function automatic void tally_word(input logic [mlv_pkg::KIND_W-1:0] k,
			input logic signed [mlv_pkg::LAB_W-1:0] lab,
			input logic signed [mlv_pkg::LAB_W-1:0] old, input logic cc);
		mlv_pkg::res_t r;
		int best;
		longint unsigned lhs;
		longint unsigned rhs;
		r = '0;
		case (k)
			mlv_pkg::KIND_VOTE: begin
				if (lab >= 0 && int'(lab) < live_labels())
					if (vote_hist[lab[mlv_pkg::LBL_BITS-1:0]] != mlv_pkg::CNT_MAX)
						vote_hist[lab[mlv_pkg::LBL_BITS-1:0]]++;
			end
			mlv_pkg::KIND_CLOSE: begin
				best = leading_label();
				r.report_kind  = mlv_pkg::RPT_GROUP;
				r.winner_label = best[mlv_pkg::LBL_BITS-1:0];
				r.changed      = (int'(old) != best);
				if (r.changed && cc && change_ctr != mlv_pkg::CHG_MAX)
					change_ctr++;
				r.change_total = change_ctr;
				clear_hist();
				pending_reports = {pending_reports, r};
			end
			mlv_pkg::KIND_SWEEP: begin
				lhs = longint'(change_ctr) << mlv_pkg::FRAC_W;
				rhs = longint'(reg_tol) * longint'(reg_nverts);
				r.report_kind  = mlv_pkg::RPT_SWEEP;
				r.converged    = (lhs < rhs);
				r.change_total = change_ctr;
				change_ctr = '0;
				pending_reports = {pending_reports, r};
			end
			default: ;
		endcase
	endfunction

	// one word through the input queue; ends at the accepting edge with push high
	task automatic send_word(input logic [mlv_pkg::KIND_W-1:0] k,
			input logic signed [mlv_pkg::LAB_W-1:0] lab,
			input logic signed [mlv_pkg::LAB_W-1:0] old, input logic cc);
		while ($urandom_range(99) < send_idle_pct) begin
			@(negedge clk);
			push = 1'b0;
			@(posedge clk);
		end
		@(negedge clk);
		push          = 1'b1;
		kind          = k;
		label         = lab;
		old_label     = old;
		count_changes = cc;
		do @(posedge clk); while (full);
		tally_word(k, lab, old, cc);
	endtask

	task automatic drain_results();
		@(negedge clk);
		push = 1'b0;
		while (pending_reports.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_reg(input logic [mlv_pkg::IDX_W-1:0] idx,
			input logic [mlv_pkg::CFG_W-1:0] data);
		@(negedge clk);
		cfg_we    = 1'b1;
		cfg_index = idx;
		cfg_data  = data;
		@(negedge clk);
		cfg_we = 1'b0;
		case (idx)
			mlv_pkg::REG_NUM_LABELS:   reg_nlabels = data[mlv_pkg::NL_W-1:0];
			mlv_pkg::REG_TOLERANCE:    reg_tol     = data[mlv_pkg::TOL_W-1:0];
			mlv_pkg::REG_VERTEX_COUNT: reg_nverts  = data[mlv_pkg::NV_W-1:0];
			default: ;
		endcase
	endtask

	task automatic set_regs(input logic [mlv_pkg::NL_W-1:0] nl,
			input logic [mlv_pkg::TOL_W-1:0] tol, input logic [mlv_pkg::NV_W-1:0] nv);
		drain_results();
		write_reg(mlv_pkg::REG_NUM_LABELS, mlv_pkg::CFG_W'(nl));
		write_reg(mlv_pkg::REG_TOLERANCE, mlv_pkg::CFG_W'(tol));
		write_reg(mlv_pkg::REG_VERTEX_COUNT, mlv_pkg::CFG_W'(nv));
	endtask

	task automatic set_random_regs();
		logic [mlv_pkg::NL_W-1:0]  nl;
		logic [mlv_pkg::TOL_W-1:0] tol;
		logic [mlv_pkg::NV_W-1:0]  nv;
		case ($urandom_range(0, 4))
			0: nl = mlv_pkg::NL_W'(1);
			1: nl = mlv_pkg::NL_W'(64);
			2: nl = mlv_pkg::NL_W'($urandom_range(2, 8));
			3: nl = mlv_pkg::NL_W'($urandom_range(1, 64));
			default: nl = mlv_pkg::NL_W'($urandom_range(0, 127));
		endcase
		case ($urandom_range(0, 3))
			0: tol = mlv_pkg::TOL_W'(0);
			1: tol = mlv_pkg::TOL_W'(65536);
			default: tol = mlv_pkg::TOL_W'($urandom_range(0, 65536));
		endcase
		case ($urandom_range(0, 3))
			0: nv = mlv_pkg::NV_W'(16777216);
			1: nv = mlv_pkg::NV_W'(1);
			default: nv = mlv_pkg::NV_W'($urandom_range(1, 300));
		endcase
		set_regs(nl, tol, nv);
	endtask

	function automatic logic signed [mlv_pkg::LAB_W-1:0] pick_vote_label();
		int n;
		n = live_labels();
		case ($urandom_range(0, 9))
			8: return mlv_pkg::LAB_W'($urandom);
			9: begin
				case ($urandom_range(0, 3))
					0: return -1;
					1: return mlv_pkg::LAB_W'(n);
					2: return 16'sh7fff;
					default: return 16'sh8000;
				endcase
			end
			default: return mlv_pkg::LAB_W'($urandom_range(0, n - 1));
		endcase
	endfunction

	// empty group, out-of-range votes, ties, unused kind, both sweep outcomes
	task automatic test_vote_basics();
		send_word(mlv_pkg::KIND_CLOSE, 0, 0, 1'b1);
		send_word(mlv_pkg::KIND_CLOSE, 0, 16'sh8000, 1'b1);
		send_word(mlv_pkg::KIND_VOTE, -1, 0, 1'b0);
		send_word(mlv_pkg::KIND_VOTE, 16'sh7fff, 0, 1'b0);
		send_word(mlv_pkg::KIND_VOTE, 16'sh8000, 0, 1'b0);
		send_word(mlv_pkg::KIND_VOTE, 64, 0, 1'b0);
		send_word(mlv_pkg::KIND_VOTE, 63, 0, 1'b0);
		send_word(mlv_pkg::KIND_VOTE, 0, 0, 1'b1);
		send_word(mlv_pkg::KIND_VOTE, 63, 0, 1'b0);
		send_word(KIND_NONE, 0, 0, 1'b1);
		send_word(mlv_pkg::KIND_CLOSE, 16'sh5a5a, 63, 1'b1);
		send_word(mlv_pkg::KIND_VOTE, 5, 0, 1'b0);
		send_word(mlv_pkg::KIND_VOTE, 7, 0, 1'b0);
		send_word(mlv_pkg::KIND_VOTE, 7, 0, 1'b0);
		send_word(mlv_pkg::KIND_VOTE, 5, 0, 1'b0);
		send_word(mlv_pkg::KIND_CLOSE, 0, 16'sh7fff, 1'b0);
		send_word(mlv_pkg::KIND_VOTE, 7, 0, 1'b0);
		send_word(mlv_pkg::KIND_VOTE, 7, 0, 1'b0);
		send_word(mlv_pkg::KIND_CLOSE, 0, 5, 1'b1);
		send_word(mlv_pkg::KIND_SWEEP, 16'shffff, 16'shffff, 1'b1);
		send_word(mlv_pkg::KIND_SWEEP, 0, 0, 1'b0);
	endtask

	// label-count clamp and convergence compare at the register extremes
	task automatic test_register_extremes();
		set_regs(2, 655, 1);
		send_word(mlv_pkg::KIND_VOTE, 1, 0, 1'b0);
		send_word(mlv_pkg::KIND_CLOSE, 0, 1, 1'b1);
		set_regs(1, 655, 1);
		send_word(mlv_pkg::KIND_VOTE, 1, 0, 1'b0);
		send_word(mlv_pkg::KIND_VOTE, 1, 0, 1'b0);
		send_word(mlv_pkg::KIND_CLOSE, 0, 1, 1'b1);
		set_regs(0, 655, 1);
		send_word(mlv_pkg::KIND_VOTE, 1, 0, 1'b0);
		send_word(mlv_pkg::KIND_CLOSE, 0, 0, 1'b1);
		set_regs(127, 0, 16777216);
		send_word(mlv_pkg::KIND_VOTE, 63, 0, 1'b0);
		send_word(mlv_pkg::KIND_CLOSE, 0, 0, 1'b1);
		send_word(mlv_pkg::KIND_SWEEP, 0, 0, 1'b0);
		set_regs(64, 65536, 0);
		send_word(mlv_pkg::KIND_SWEEP, 0, 0, 1'b0);
		set_regs(64, 65536, 16777216);
		send_word(mlv_pkg::KIND_CLOSE, 0, 9, 1'b1);
		send_word(mlv_pkg::KIND_SWEEP, 0, 0, 1'b0);
		// boundary: one change times 65536 equals the product
		set_regs(64, 1, 65536);
		send_word(mlv_pkg::KIND_CLOSE, 0, 9, 1'b1);
		send_word(mlv_pkg::KIND_SWEEP, 0, 0, 1'b0);
		send_word(mlv_pkg::KIND_SWEEP, 0, 0, 1'b0);
	endtask

	// vote groups closed on matching or differing old labels, sweeps, unused words
	task automatic test_random_groups(input int words);
		int sent;
		int votes;
		int sel;
		logic signed [mlv_pkg::LAB_W-1:0] old;
		sent = 0;
		while (sent < words) begin
			if (sent % 90 == 0)
				set_random_regs();
			sel = $urandom_range(0, 99);
			if (sel < 3) begin
				send_word(KIND_NONE, mlv_pkg::LAB_W'($urandom),
					mlv_pkg::LAB_W'($urandom), 1'($urandom));
				sent++;
			end else if (sel < 10) begin
				send_word(mlv_pkg::KIND_SWEEP, mlv_pkg::LAB_W'($urandom),
					mlv_pkg::LAB_W'($urandom), 1'($urandom));
				sent++;
			end else begin
				votes = ($urandom_range(0, 9) == 0) ? $urandom_range(11, 30) :
					$urandom_range(0, 10);
				repeat (votes) begin
					send_word(mlv_pkg::KIND_VOTE, pick_vote_label(),
						mlv_pkg::LAB_W'($urandom), 1'($urandom));
					sent++;
				end
				case ($urandom_range(0, 3))
					0, 1: old = mlv_pkg::LAB_W'(leading_label());
					2: old = mlv_pkg::LAB_W'($urandom_range(0, live_labels() - 1));
					default: old = mlv_pkg::LAB_W'($urandom);
				endcase
				send_word(mlv_pkg::KIND_CLOSE, mlv_pkg::LAB_W'($urandom), old,
					1'($urandom));
				sent++;
			end
		end
	endtask

	// result side held off long enough for both queues to fill, then drained
	task automatic test_backpressure();
		set_random_regs();
		pop_holdoff = 600;
		repeat (10) begin
			repeat (3) send_word(mlv_pkg::KIND_VOTE, pick_vote_label(), 0, 1'b0);
			send_word(mlv_pkg::KIND_CLOSE, 0, mlv_pkg::LAB_W'($urandom_range(0, 3)), 1'b1);
		end
		drain_results();
		repeat (5) begin
			send_word(mlv_pkg::KIND_VOTE, pick_vote_label(), 0, 1'b0);
			send_word(mlv_pkg::KIND_CLOSE, 0, 0, 1'b1);
		end
		send_word(mlv_pkg::KIND_SWEEP, 0, 0, 1'b0);
	endtask

	initial begin
		pop = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(negedge clk);
			if (pop_holdoff > 0) begin
				pop = 1'b0;
				pop_holdoff--;
			end else begin
				pop = ($urandom_range(99) >= recv_idle_pct);
			end
		end
	end

	always @(posedge clk) begin
		mlv_pkg::res_t want;
		if (arst_n && pop && !empty) begin
			if (pending_reports.size() == 0) begin
				report_error("result word with nothing expected");
			end else begin
				want = pending_reports.pop_front();
				if (report_kind !== want.report_kind)
					report_error($sformatf("report_kind %0b, want %0b",
						report_kind, want.report_kind));
				if (winner_label !== want.winner_label)
					report_error($sformatf("winner_label %0d, want %0d",
						winner_label, want.winner_label));
				if (changed !== want.changed)
					report_error($sformatf("changed %0b, want %0b", changed, want.changed));
				if (converged !== want.converged)
					report_error($sformatf("converged %0b, want %0b",
						converged, want.converged));
				if (change_total !== want.change_total)
					report_error($sformatf("change_total %0d, want %0d",
						change_total, want.change_total));
			end
		end
	end

	initial begin
		arst_n        = 1'b0;
		push          = 1'b0;
		kind          = mlv_pkg::KIND_VOTE;
		label         = '0;
		old_label     = '0;
		count_changes = 1'b0;
		cfg_we        = 1'b0;
		cfg_index     = mlv_pkg::REG_NUM_LABELS;
		cfg_data      = '0;
		reset_model();
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		send_idle_pct = 7;
		recv_idle_pct = 63;
		test_vote_basics();
		test_register_extremes();
		test_random_groups(240);

		send_idle_pct = 63;
		recv_idle_pct = 7;
		test_random_groups(240);
		test_backpressure();

		send_idle_pct = 0;
		recv_idle_pct = 0;
		test_random_groups(240);

		drain_results();
		repeat (100) @(posedge clk);
		if (pending_reports.size() != 0)
			report_error($sformatf("%0d results never arrived", pending_reports.size()));
		if (err_count == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
